// ===== hw/rtl/svpd_pkg.sv =====
// shared types, widths and coefficients of the space vector pwm duty block
package svpd_pkg;

    // input sample format and the internal q23 word
    localparam int SAMPLE_WIDTH = 16;
    localparam int Q23_W        = 24;
    localparam int Q23_SHIFT    = Q23_W - SAMPLE_WIDTH;

    // widths of intermediate words
    localparam int ACC_W  = 42;   // coefficient products
    localparam int AB_W   = 25;   // alpha, beta and their scaled forms
    localparam int D_W    = 27;   // raw q23 duties before rounding
    localparam int TIME_W = 15;   // q15 duties
    localparam int SUM_W  = 16;   // sum of two q15 duties
    localparam int CMP_W  = 16;   // timer compare values
    localparam int PRD_W  = 16;   // period register
    localparam int MUL_W  = 32;   // period times duty
    localparam int CODE_W = 3;    // sector and switch codes

    // q16 coefficients
    localparam logic signed [17:0] K_TWO_THIRDS    = 18'sd43693;
    localparam logic signed [17:0] K_ONE_THIRD     = 18'sd21843;
    localparam logic signed [17:0] K_CLARKE_BETA   = 18'sd37840;
    localparam logic signed [17:0] K_COS30         = 18'sd56754;
    localparam logic signed [17:0] K_INV_SQRT3     = 18'sd37837;
    localparam logic signed [17:0] K_TWO_INV_SQRT3 = 18'sd75674;

    // rounding offsets, half an lsb rounded toward plus infinity
    localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);
    localparam logic signed [D_W-1:0]   HALF_Q8  = D_W'(128);

    localparam logic [TIME_W-1:0] TIME_MAX  = 15'd32767;
    localparam logic [SUM_W-1:0]  FULL_DUTY = 16'd32768;
    localparam logic [CMP_W-1:0]  CMP_MAX   = 16'hFFFF;

    localparam logic [PRD_W-1:0] PERIOD_RESET = 16'd14399;

    // sector numbers
    localparam logic [CODE_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [CODE_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [CODE_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [CODE_W-1:0] SECTOR_4 = 3'd4;
    localparam logic [CODE_W-1:0] SECTOR_5 = 3'd5;
    localparam logic [CODE_W-1:0] SECTOR_6 = 3'd6;

    // switch patterns, bits c b a
    localparam logic [CODE_W-1:0] VEC_A  = 3'b001;
    localparam logic [CODE_W-1:0] VEC_B  = 3'b010;
    localparam logic [CODE_W-1:0] VEC_AB = 3'b011;
    localparam logic [CODE_W-1:0] VEC_C  = 3'b100;
    localparam logic [CODE_W-1:0] VEC_AC = 3'b101;
    localparam logic [CODE_W-1:0] VEC_BC = 3'b110;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] phase_a_ref;
        logic signed [SAMPLE_WIDTH-1:0] phase_b_ref;
        logic signed [SAMPLE_WIDTH-1:0] phase_c_ref;
    } t_svpd_in;

    typedef struct packed {
        logic [CODE_W-1:0] sector;
        logic [CODE_W-1:0] vector_first;
        logic [CODE_W-1:0] vector_second;
        logic [TIME_W-1:0] time_first;
        logic [TIME_W-1:0] time_second;
        logic [TIME_W-1:0] time_zero;
        logic [CMP_W-1:0]  compare_one;
        logic [CMP_W-1:0]  compare_two;
        logic [CMP_W-1:0]  compare_three;
        logic              overmodulation;
    } t_svpd_out;

    // alpha and beta in q23
    typedef struct packed {
        logic signed [AB_W-1:0] alpha;
        logic signed [AB_W-1:0] beta;
    } t_ab;

    // sector decision and raw duties
    typedef struct packed {
        logic [CODE_W-1:0]     sector;
        logic [CODE_W-1:0]     vec_first;
        logic [CODE_W-1:0]     vec_second;
        logic signed [D_W-1:0] d_first;
        logic signed [D_W-1:0] d_second;
    } t_sect;

    // q15 duties, ready for the timer scaling
    typedef struct packed {
        logic [CODE_W-1:0] sector;
        logic [CODE_W-1:0] vec_first;
        logic [CODE_W-1:0] vec_second;
        logic [TIME_W-1:0] t_first;
        logic [TIME_W-1:0] t_second;
        logic [TIME_W-1:0] t_zero;
        logic [SUM_W-1:0]  zero_first;   // t_zero + t_first
        logic              ovm;
    } t_duty;

endpackage

// ===== hw/rtl/svpd_clarke.sv =====
// clarke transform, two pipeline stages: coefficient products, then rounding
module svpd_clarke (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  svpd_pkg::t_svpd_in i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output svpd_pkg::t_ab      o_data
);
    import svpd_pkg::*;

    logic signed [Q23_W-1:0] q_a;
    logic signed [Q23_W-1:0] q_b;
    logic signed [Q23_W-1:0] q_c;
    logic signed [ACC_W-1:0] n_num_al;
    logic signed [ACC_W-1:0] n_num_be;
    logic signed [ACC_W-1:0] r_num_al;
    logic signed [ACC_W-1:0] r_num_be;
    logic                    r_v1;
    logic                    rdy1;
    t_ab                     n_ab;
    t_ab                     r_ab;
    logic                    r_v2;
    logic                    rdy2;

    // widen to q23
    assign q_a = Q23_W'(i_data.phase_a_ref) <<< Q23_SHIFT;
    assign q_b = Q23_W'(i_data.phase_b_ref) <<< Q23_SHIFT;
    assign q_c = Q23_W'(i_data.phase_c_ref) <<< Q23_SHIFT;

    assign n_num_al = ACC_W'(K_TWO_THIRDS) * ACC_W'(q_a)
                    - ACC_W'(K_ONE_THIRD) * (ACC_W'(q_b) + ACC_W'(q_c));
    assign n_num_be = ACC_W'(K_CLARKE_BETA) * (ACC_W'(q_b) - ACC_W'(q_c));

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_num_al <= n_num_al;
            r_num_be <= n_num_be;
        end
    end

    assign n_ab.alpha = AB_W'((r_num_al + HALF_Q16) >>> 16);
    assign n_ab.beta  = AB_W'((r_num_be + HALF_Q16) >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_ab <= n_ab;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_ab;

endmodule

// ===== hw/rtl/svpd_sector.sv =====
// sector decision and raw duties, two stages: products, then sign tests and select
module svpd_sector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  svpd_pkg::t_ab i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output svpd_pkg::t_sect o_data
);
    import svpd_pkg::*;

    // sign patterns {u3 > 0, u2 > 0, beta > 0}
    localparam logic [2:0] PAT_S2 = 3'b001;
    localparam logic [2:0] PAT_S3 = 3'b101;
    localparam logic [2:0] PAT_S4 = 3'b100;
    localparam logic [2:0] PAT_S5 = 3'b110;
    localparam logic [2:0] PAT_S6 = 3'b010;

    logic signed [ACC_W-1:0] r_p_cos;
    logic signed [ACC_W-1:0] r_p_bs;
    logic signed [ACC_W-1:0] r_p_bl;
    logic signed [AB_W-1:0]  r_al;
    logic signed [AB_W-1:0]  r_be;
    logic                    r_v1;
    logic                    rdy1;
    logic signed [ACC_W-1:0] be_sh;
    logic signed [ACC_W-1:0] u2;
    logic signed [ACC_W-1:0] u3;
    logic [2:0]              pat;
    logic signed [D_W-1:0]   al;
    logic signed [D_W-1:0]   bs;
    logic signed [D_W-1:0]   bl;
    t_sect                   n_sect;
    t_sect                   r_sect;
    logic                    r_v2;
    logic                    rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p_cos <= ACC_W'(K_COS30) * ACC_W'(i_data.alpha);
            r_p_bs  <= ACC_W'(K_INV_SQRT3) * ACC_W'(i_data.beta);
            r_p_bl  <= ACC_W'(K_TWO_INV_SQRT3) * ACC_W'(i_data.beta);
            r_al    <= i_data.alpha;
            r_be    <= i_data.beta;
        end
    end

    // beta / 2 scaled to the product's q16 frame
    assign be_sh = ACC_W'(r_be) <<< 15;
    assign u2    = r_p_cos - be_sh;
    assign u3    = -r_p_cos - be_sh;
    assign pat   = {u3 > 0, u2 > 0, r_be > 0};

    assign al = D_W'(r_al);
    assign bs = D_W'((r_p_bs + HALF_Q16) >>> 16);
    assign bl = D_W'((r_p_bl + HALF_Q16) >>> 16);

    always_comb begin
        case (pat)
            PAT_S2: begin
                n_sect = '{SECTOR_2, VEC_B, VEC_BC, -al + bs, al + bs};
            end
            PAT_S3: begin
                n_sect = '{SECTOR_3, VEC_B, VEC_AB, bl, -al - bs};
            end
            PAT_S4: begin
                n_sect = '{SECTOR_4, VEC_A, VEC_AB, -bl, -al + bs};
            end
            PAT_S5: begin
                n_sect = '{SECTOR_5, VEC_A, VEC_AC, -al - bs, al - bs};
            end
            PAT_S6: begin
                n_sect = '{SECTOR_6, VEC_C, VEC_AC, al + bs, -bl};
            end
            default: begin
                // sector 1, also zero vector and the all-positive pattern
                n_sect = '{SECTOR_1, VEC_C, VEC_BC, al - bs, bl};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_sect <= n_sect;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_sect;

endmodule

// ===== hw/rtl/svpd_duty.sv =====
// q15 duty rounding, clamping and zero time, one stage
module svpd_duty (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_sect i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_duty o_data
);
    import svpd_pkg::*;

    function automatic logic [TIME_W-1:0] duty_sat(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] r;
        logic [TIME_W-1:0]     t;
        r = (d + HALF_Q8) >>> 8;
        if (r < 0) begin
            t = '0;
        end else if (r > D_W'(TIME_MAX)) begin
            t = TIME_MAX;
        end else begin
            t = TIME_W'(r);
        end
        return t;
    endfunction

    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    logic [SUM_W-1:0]  sum_t;
    logic              ovm;
    t_duty             n_duty;
    t_duty             r_duty;
    logic              r_v;
    logic              rdy;

    assign t1    = duty_sat(i_data.d_first);
    assign t2    = duty_sat(i_data.d_second);
    assign sum_t = SUM_W'(t1) + SUM_W'(t2);
    assign ovm   = sum_t > FULL_DUTY;

    always_comb begin
        n_duty.sector     = i_data.sector;
        n_duty.vec_first  = i_data.vec_first;
        n_duty.vec_second = i_data.vec_second;
        n_duty.t_first    = t1;
        n_duty.t_second   = t2;
        n_duty.ovm        = ovm;
        if (ovm) begin
            n_duty.t_zero     = '0;
            n_duty.zero_first = SUM_W'(t1);
        end else if (sum_t == '0) begin
            // full zero time saturates one lsb short of 1.0
            n_duty.t_zero     = TIME_MAX;
            n_duty.zero_first = SUM_W'(TIME_MAX);
        end else begin
            n_duty.t_zero     = TIME_W'(FULL_DUTY - sum_t);
            n_duty.zero_first = FULL_DUTY - SUM_W'(t2);
        end
    end

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_duty <= n_duty;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_duty;

endmodule

// ===== hw/rtl/svpd_compare.sv =====
// timer compare values, two stages: period products, then rounding and saturating sums
module svpd_compare (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [svpd_pkg::PRD_W-1:0] i_period,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  svpd_pkg::t_duty            i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output svpd_pkg::t_svpd_out        o_data
);
    import svpd_pkg::*;

    function automatic logic [CMP_W-1:0] sat16(input logic [CMP_W:0] v);
        logic [CMP_W-1:0] s;
        if (v[CMP_W]) begin
            s = CMP_MAX;
        end else begin
            s = v[CMP_W-1:0];
        end
        return s;
    endfunction

    logic [MUL_W-1:0] r_m1;
    logic [MUL_W-1:0] r_m2;
    logic [MUL_W-1:0] r_m3;
    t_duty            r_duty;
    logic             r_v1;
    logic             rdy1;
    logic [CMP_W:0]   rnd1;
    logic [CMP_W:0]   rnd2;
    logic [CMP_W:0]   rnd3;
    logic [CMP_W-1:0] c1;
    logic [CMP_W-1:0] c2;
    logic [CMP_W-1:0] c3;
    t_svpd_out        n_out;
    t_svpd_out        r_out;
    logic             r_v2;
    logic             rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_m1   <= MUL_W'(i_period) * MUL_W'(i_data.zero_first);
            r_m2   <= MUL_W'(i_period) * MUL_W'(i_data.t_second);
            r_m3   <= MUL_W'(i_period) * MUL_W'(i_data.t_first);
            r_duty <= i_data;
        end
    end

    // products stay below 2^31, so the rounding adds cannot wrap
    assign rnd1 = (CMP_W + 1)'((r_m1 + MUL_W'(32768)) >> 16);
    assign rnd2 = (CMP_W + 1)'((r_m2 + MUL_W'(16384)) >> 15);
    assign rnd3 = (CMP_W + 1)'((r_m3 + MUL_W'(32768)) >> 16);
    assign c1   = sat16(rnd1);
    assign c2   = sat16({1'b0, c1} + rnd2);
    assign c3   = sat16({1'b0, c2} + rnd3);

    assign n_out = '{
        sector:         r_duty.sector,
        vector_first:   r_duty.vec_first,
        vector_second:  r_duty.vec_second,
        time_first:     r_duty.t_first,
        time_second:    r_duty.t_second,
        time_zero:      r_duty.t_zero,
        compare_one:    c1,
        compare_two:    c2,
        compare_three:  c3,
        overmodulation: r_duty.ovm
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/space_vector_pwm_duty.sv =====
// space vector pwm duty calculator, top level
// Takes one triple of Q1.15 phase references per item and returns the sector (1 to 6),
// the two active switch patterns (bits C B A), the Q15 active and zero duties, an
// overmodulation flag and three cumulative timer compare values scaled by the period
// register. The datapath is a seven-stage pipeline: Clarke products, alpha/beta rounding,
// sector products, sign tests and duty select, Q15 rounding and zero time, period
// products, compare rounding and saturation. The last stage is the output register.
// One item is accepted in every cycle as long as results are taken; a stalled output lets
// empty stages fill up before the input stops. compare_period resets to 14399 and is read
// live by the period product stage, so write it only while no item is in flight; the write
// port is always ready. A zero reference gives sector 1 with full zero time
// (clamped to 32767).
module space_vector_pwm_duty (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write, compare_period
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [svpd_pkg::PRD_W-1:0] i_cfg_data,
    // reference items in
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  svpd_pkg::t_svpd_in         i_in_data,
    // result items out
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output svpd_pkg::t_svpd_out        o_out_data
);
    import svpd_pkg::*;

    logic [PRD_W-1:0] r_compare_period;

    // handshakes between the pipeline sections
    logic  ab_valid;
    logic  ab_ready;
    t_ab   ab_data;
    logic  sect_valid;
    logic  sect_ready;
    t_sect sect_data;
    logic  duty_valid;
    logic  duty_ready;
    t_duty duty_data;

    // period register; the write port is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compare_period <= i_cfg_data;
        end
    end

    // stages one and two: alpha and beta
    svpd_clarke u_clarke (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (ab_valid),
        .i_ready (ab_ready),
        .o_data  (ab_data)
    );

    // stages three and four: sector, switch patterns, raw duties
    svpd_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ab_valid),
        .o_ready (ab_ready),
        .i_data  (ab_data),
        .o_valid (sect_valid),
        .i_ready (sect_ready),
        .o_data  (sect_data)
    );

    // stage five: q15 duties, zero time, overmodulation
    svpd_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sect_valid),
        .o_ready (sect_ready),
        .i_data  (sect_data),
        .o_valid (duty_valid),
        .i_ready (duty_ready),
        .o_data  (duty_data)
    );

    // stages six and seven: compare values, output register
    svpd_compare u_compare (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_compare_period),
        .i_valid  (duty_valid),
        .o_ready  (duty_ready),
        .i_data   (duty_data),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

    // an empty output register means no stage can be holding back the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    // compare values are cumulative and never step back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.compare_two >= o_out_data.compare_one)
                     && (o_out_data.compare_three >= o_out_data.compare_two))
        else $error("compare values out of order");

    // overmodulation leaves no zero time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overmodulation |-> o_out_data.time_zero == '0)
        else $error("zero time nonzero under overmodulation");

    // without overmodulation duties fill exactly one period, or zero time alone is 32767
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.overmodulation |->
            (17'(o_out_data.time_first) + 17'(o_out_data.time_second)
             + 17'(o_out_data.time_zero) == 17'd32768)
            || (o_out_data.time_zero == TIME_MAX && o_out_data.time_first == '0
                && o_out_data.time_second == '0))
        else $error("duties do not sum to one period");

    // the sector number never leaves 1 to 6
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sector != 3'd0 && o_out_data.sector != 3'd7)
        else $error("sector out of range");

endmodule

// ===== sim/tb_space_vector_pwm_duty.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the space vector pwm duty calculator, directed and random items
module tb_space_vector_pwm_duty;
    import svpd_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_DEPTH   = 7;     // pipeline depth, used to size the final drain wait
    localparam int LONG_HOLD    = 60;    // long output stall, far more than the pipe holds
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 105;
    localparam int HOLD_BURST_ITEMS = 40;

    // q16 coefficients, kept apart from the design's copy
    localparam longint Q16_TWO_THIRDS    = 43693;
    localparam longint Q16_ONE_THIRD     = 21843;
    localparam longint Q16_BETA_GAIN     = 37840;
    localparam longint Q16_COS30         = 56754;
    localparam longint Q16_INV_SQRT3     = 37837;
    localparam longint Q16_TWO_INV_SQRT3 = 75674;

    localparam int     PERIOD_AFTER_RESET = 14399;
    localparam longint FULL_Q15           = 32768;
    localparam longint MAX_Q15            = 32767;
    localparam longint MAX_COMPARE        = 65535;

    // sign tests {u3 > 0, u2 > 0, beta > 0} that pick sectors two to six,
    // anything else (zero vector, impossible pattern, sector one) falls to sector one
    localparam bit [2:0] SIGNS_SECTOR_2 = 3'b001;
    localparam bit [2:0] SIGNS_SECTOR_3 = 3'b101;
    localparam bit [2:0] SIGNS_SECTOR_4 = 3'b100;
    localparam bit [2:0] SIGNS_SECTOR_5 = 3'b110;
    localparam bit [2:0] SIGNS_SECTOR_6 = 3'b010;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [PRD_W-1:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_svpd_in   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_svpd_out  out_data;

    // predicted results in acceptance order, and the period they were computed with
    t_svpd_out  expected_duty[$];
    int         period_setting = PERIOD_AFTER_RESET;
    int         mismatches     = 0;
    int         idle_cycles    = 0;

    // idling controls, changed per phase by the tests
    bit         sender_idles   = 1'b0;
    bit         receiver_idles = 1'b0;
    bit         hold_request   = 1'b0;

    space_vector_pwm_duty DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // duty predictor
    // ------------------------------------------------------------------

    // round to nearest, ties toward plus infinity, as an arithmetic shift
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // q23 duty to saturated q15
    function automatic longint to_q15(input longint q23);
        longint d;
        d = round_half_up(q23, 8);
        if (d < 0) d = 0;
        if (d > MAX_Q15) d = MAX_Q15;
        return d;
    endfunction

    function automatic longint clamp_compare(input longint v);
        return (v > MAX_COMPARE) ? MAX_COMPARE : v;
    endfunction

    function automatic t_svpd_out predict_duty(input t_svpd_in refs, input int period);
        longint a, b, c, alpha, beta, u2, u3, beta_s, beta_l;
        longint d1, d2, t1, t2, tz, c1, c2, c3, prd;
        bit [2:0] signs;
        t_svpd_out res;
        prd = longint'(period);
        // q1.15 samples widened to q23
        a = longint'($signed(refs.phase_a_ref)) * 256;
        b = longint'($signed(refs.phase_b_ref)) * 256;
        c = longint'($signed(refs.phase_c_ref)) * 256;
        // clarke transform
        alpha = round_half_up(Q16_TWO_THIRDS * a - Q16_ONE_THIRD * b - Q16_ONE_THIRD * c, 16);
        beta  = round_half_up(Q16_BETA_GAIN * (b - c), 16);
        // sector sign tests
        u2 = Q16_COS30 * alpha - 32768 * beta;
        u3 = -Q16_COS30 * alpha - 32768 * beta;
        signs  = {u3 > 0, u2 > 0, beta > 0};
        beta_s = round_half_up(Q16_INV_SQRT3 * beta, 16);
        beta_l = round_half_up(Q16_TWO_INV_SQRT3 * beta, 16);
        res = '0;
        case (signs)
            SIGNS_SECTOR_2: begin
                res.sector = SECTOR_2; res.vector_first = VEC_B; res.vector_second = VEC_BC;
                d1 = -alpha + beta_s; d2 = alpha + beta_s;
            end
            SIGNS_SECTOR_3: begin
                res.sector = SECTOR_3; res.vector_first = VEC_B; res.vector_second = VEC_AB;
                d1 = beta_l; d2 = -alpha - beta_s;
            end
            SIGNS_SECTOR_4: begin
                res.sector = SECTOR_4; res.vector_first = VEC_A; res.vector_second = VEC_AB;
                d1 = -beta_l; d2 = -alpha + beta_s;
            end
            SIGNS_SECTOR_5: begin
                res.sector = SECTOR_5; res.vector_first = VEC_A; res.vector_second = VEC_AC;
                d1 = -alpha - beta_s; d2 = alpha - beta_s;
            end
            SIGNS_SECTOR_6: begin
                res.sector = SECTOR_6; res.vector_first = VEC_C; res.vector_second = VEC_AC;
                d1 = alpha + beta_s; d2 = -beta_l;
            end
            default: begin
                res.sector = SECTOR_1; res.vector_first = VEC_C; res.vector_second = VEC_BC;
                d1 = alpha - beta_s; d2 = beta_l;
            end
        endcase
        t1 = to_q15(d1);
        t2 = to_q15(d2);
        // zero time, negative means overmodulation, a full period is clamped
        tz = FULL_Q15 - t1 - t2;
        res.overmodulation = (tz < 0);
        if (tz < 0) tz = 0;
        if (tz > MAX_Q15) tz = MAX_Q15;
        // cumulative timer compares
        c1 = clamp_compare((prd * (tz + t1) + 32768) >>> 16);
        c2 = clamp_compare(c1 + ((prd * t2 + 16384) >>> 15));
        c3 = clamp_compare(c2 + ((prd * t1 + 32768) >>> 16));
        res.time_first    = TIME_W'(t1);
        res.time_second   = TIME_W'(t2);
        res.time_zero     = TIME_W'(tz);
        res.compare_one   = CMP_W'(c1);
        res.compare_two   = CMP_W'(c2);
        res.compare_three = CMP_W'(c3);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_svpd_in phase_refs(input int a, input int b, input int c);
        t_svpd_in refs;
        refs.phase_a_ref = SAMPLE_WIDTH'(a);
        refs.phase_b_ref = SAMPLE_WIDTH'(b);
        refs.phase_c_ref = SAMPLE_WIDTH'(c);
        return refs;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int corner_sample();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic t_svpd_in random_reference();
        int span, pa, pb, pc, v1, v2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // balanced set with zero sum unless the third phase clamps, amplitude over octaves 4 to 15
                span = (1 << $urandom_range(4, 15)) - 1;
                pa = int'($urandom_range(0, 2 * span)) - span;
                pb = int'($urandom_range(0, 2 * span)) - span;
                pc = -(pa + pb);
                if (pc > 32767) pc = 32767;
                if (pc < -32768) pc = -32768;
                case ($urandom_range(0, 2))
                    0: return phase_refs(pa, pb, pc);
                    1: return phase_refs(pc, pa, pb);
                    default: return phase_refs(pb, pc, pa);
                endcase
            end
            5, 6: return phase_refs(int'($urandom), int'($urandom), int'($urandom));
            7: begin
                // tiny values, rounding at the sector borders
                return phase_refs(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                                  int'($urandom_range(0, 8)) - 4);
            end
            8: return phase_refs(corner_sample(), corner_sample(), corner_sample());
            default: begin
                // two equal phases put the vector right on a sector edge
                v1 = int'($urandom);
                v2 = int'($urandom);
                case ($urandom_range(0, 2))
                    0: return phase_refs(v1, v2, v2);
                    1: return phase_refs(v2, v1, v2);
                    default: return phase_refs(v2, v2, v1);
                endcase
            end
        endcase
    endfunction

    // offer one item, with an optional gap first, and predict its result on acceptance
    task automatic send_reference(input t_svpd_in refs);
        int gap;
        gap = (sender_idles && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= refs;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_duty.push_back(predict_duty(refs, period_setting));
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic await_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_duty.size() != 0);
    endtask

    // period write, only ever called with nothing in flight
    task automatic write_period(input int value);
        cfg_data  <= PRD_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        period_setting = value & 16'hFFFF;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes at the reset period: zero vector with full zero time,
    // pure phase vectors, clamped large duty, overmodulation, one-lsb inputs
    task automatic test_extremes();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_reference(phase_refs(0, 0, 0));
        send_reference(phase_refs(32767, 32767, 32767));
        send_reference(phase_refs(-32768, -32768, -32768));
        send_reference(phase_refs(32767, 0, 0));
        send_reference(phase_refs(-32768, 0, 0));
        send_reference(phase_refs(0, 32767, 0));
        send_reference(phase_refs(0, -32768, 0));
        send_reference(phase_refs(0, 0, 32767));
        send_reference(phase_refs(0, 0, -32768));
        send_reference(phase_refs(32767, -32768, -32768));
        send_reference(phase_refs(-32768, 32767, 32767));
        send_reference(phase_refs(32767, 0, -32768));
        send_reference(phase_refs(1, 0, 0));
        send_reference(phase_refs(0, 1, -1));
        await_results();
    endtask

    // one balanced vector in the middle of each sector, no idling at all
    task automatic test_sector_walk();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_reference(phase_refs(14189, 0, -14189));
        send_reference(phase_refs(0, 14189, -14189));
        send_reference(phase_refs(-14189, 14189, 0));
        send_reference(phase_refs(-14189, 0, 14189));
        send_reference(phase_refs(0, -14189, 14189));
        send_reference(phase_refs(14189, -14189, 0));
        await_results();
    endtask

    // period at zero and at full scale; at full scale overmodulated duties saturate the compares
    task automatic test_period_extremes();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        write_period(0);
        send_reference(phase_refs(32767, 0, -32768));
        send_reference(phase_refs(-32768, 0, 32767));
        send_reference(phase_refs(0, 0, 0));
        await_results();
        write_period(65535);
        send_reference(phase_refs(32767, 0, -32768));
        send_reference(phase_refs(-32768, 0, 32767));
        send_reference(phase_refs(0, 0, 0));
        await_results();
    endtask

    // receiver stops for a long stretch while items keep coming back to back,
    // so the pipeline fills up and the input stalls
    task automatic test_output_hold();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 1'b1;
        repeat (HOLD_BURST_ITEMS) send_reference(random_reference());
        await_results();
    endtask

    // random items in phases; between phases the sender waits for every result
    // and a new period goes in, every third phase runs with no idling
    task automatic test_random_phases();
        int prd;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: prd = 1;
                1: prd = 65535;
                5: prd = PERIOD_AFTER_RESET;
                default: prd = $urandom_range(0, 65535);
            endcase
            write_period(prd);
            sender_idles   = (ph % 3 != 2);
            receiver_idles = (ph % 3 != 2);
            repeat (ITEMS_PER_PHASE) send_reference(random_reference());
            await_results();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int stall;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                stall = idle_length();
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each taken result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_svpd_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_duty.size() == 0) begin
                mismatches++;
                $error("result item with no item waiting for it");
            end else begin
                want = expected_duty.pop_front();
                check_field("sector",         want.sector,         out_data.sector);
                check_field("vector_first",   want.vector_first,   out_data.vector_first);
                check_field("vector_second",  want.vector_second,  out_data.vector_second);
                check_field("time_first",     want.time_first,     out_data.time_first);
                check_field("time_second",    want.time_second,    out_data.time_second);
                check_field("time_zero",      want.time_zero,      out_data.time_zero);
                check_field("compare_one",    want.compare_one,    out_data.compare_one);
                check_field("compare_two",    want.compare_two,    out_data.compare_two);
                check_field("compare_three",  want.compare_three,  out_data.compare_three);
                check_field("overmodulation", want.overmodulation, out_data.overmodulation);
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** space_vector_pwm_duty: FAILED **");
            $finish;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_sector_walk();
        test_period_extremes();
        test_output_hold();
        test_random_phases();
        // let any stray result show up before deciding
        repeat (PIPE_DEPTH * 3) @(posedge clk);
        if (mismatches == 0 && expected_duty.size() == 0) begin
            $display("** space_vector_pwm_duty: PASSED **");
        end else begin
            $display("** space_vector_pwm_duty: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/svpd_pkg.sv
hw/rtl/svpd_clarke.sv
hw/rtl/svpd_sector.sv
hw/rtl/svpd_duty.sv
hw/rtl/svpd_compare.sv
hw/rtl/space_vector_pwm_duty.sv
sim/tb_space_vector_pwm_duty.sv
